### rtl/core/jts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jts_pkg;

  localparam int POSITION_WIDTH = 32;
  localparam int LEN_WIDTH      = 32;
  localparam int START_WIDTH    = 32;
  localparam int MAX_RES        = 3;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_LIT,
    MODE_STR,
    MODE_INT,
    MODE_DOT,
    MODE_FRAC
  } mode_e;

  typedef enum logic [3:0] {
    K_LBRACE,
    K_RBRACE,
    K_LBRACK,
    K_RBRACK,
    K_COLON,
    K_COMMA,
    K_TRUE,
    K_FALSE,
    K_NULL,
    K_STRING,
    K_NUMBER,
    K_END,
    K_BADLIT,
    K_UNCLOSED,
    K_UNSUP
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic [START_WIDTH-1:0] start;
    logic [LEN_WIDTH-1:0]   len;
    logic                   last;
  } tok_t;

  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;

  localparam logic [1:0] SEL_TRUE  = 2'd0;
  localparam logic [1:0] SEL_FALSE = 2'd1;
  localparam logic [1:0] SEL_NULL  = 2'd2;

  // Expected byte of a literal after its first letter.
  function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [1:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (sel)
      SEL_TRUE: begin
        case (idx)
          2'd0:    c = "r";
          2'd1:    c = "u";
          2'd2:    c = "e";
          default: c = 8'h00;
        endcase
      end
      SEL_FALSE: begin
        case (idx)
          2'd0:    c = "a";
          2'd1:    c = "l";
          2'd2:    c = "s";
          default: c = "e";
        endcase
      end
      default: begin
        case (idx)
          2'd0:    c = "u";
          2'd1:    c = "l";
          2'd2:    c = "l";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] sel);
    return (sel == SEL_FALSE) ? 3'd4 : 3'd3;
  endfunction

  function automatic kind_e lit_kind(input logic [1:0] sel);
    kind_e k;
    case (sel)
      SEL_TRUE:  k = K_TRUE;
      SEL_FALSE: k = K_FALSE;
      default:   k = K_NULL;
    endcase
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic [START_WIDTH-1:0] to_start(input logic [POSITION_WIDTH-1:0] p);
    logic [63:0] w;
    w = 64'(p);
    return w[START_WIDTH-1:0];
  endfunction

  function automatic tok_t mk_tok(input kind_e k, input logic [POSITION_WIDTH-1:0] s,
                                  input logic [LEN_WIDTH-1:0] l);
    tok_t t;
    t.kind  = k;
    t.start = to_start(s);
    t.len   = l;
    t.last  = 1'b0;
    return t;
  endfunction

endpackage

`default_nettype wire

### rtl/core/json_token_scanner.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake               | Payload
// input   | in        | in_valid_i / in_stall_o  | char_byte_i, is_last_i
// output  | out       | out_valid_o / out_stall_i | token_kind_o, token_start_o,
//         |           |                          | token_length_o, last_of_run_o
//
// A byte is scanned in the cycle it is accepted; its tokens (0 to 3) land in a
// three-entry result buffer and leave one per cycle while the output is not
// stalled. One byte per cycle is sustained while each byte yields at most one token
// and the output does not stall; a byte yielding more holds the input while they drain.
// Reset clears the scanner state, the position and the result buffer count.
// A stalled output holds its head token; the input stalls until the buffer
// holds at most one token that is being taken in the same cycle.
module json_token_scanner (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_byte_i,
  input  wire logic        is_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       token_kind_o,
  output logic [31:0]      token_start_o,
  output logic [31:0]      token_length_o,
  output logic             last_of_run_o
);

  localparam int PW = jts_pkg::POSITION_WIDTH;
  localparam int LW = jts_pkg::LEN_WIDTH;

  jts_pkg::mode_e  mode_q, mode_d;
  logic [1:0]      lsel_q, lsel_d;
  logic [1:0]      lidx_q, lidx_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic [PW-1:0]   start_q, start_d;
  logic            err_q, err_d;
  logic [LW-1:0]   run_q, run_d;

  jts_pkg::tok_t   buf_q [jts_pkg::MAX_RES];
  jts_pkg::tok_t   res_d [jts_pkg::MAX_RES];
  logic [1:0]      cnt_q;
  logic [1:0]      n_res;

  logic            in_fire, out_fire;
  logic            do_idle;
  logic [LW-1:0]   run_inc1, run_inc2;
  logic [7:0]      b;
  logic            lit_done;

  assign b        = char_byte_i;
  assign run_inc1 = (run_q == {LW{1'b1}}) ? run_q : run_q + LW'(1);
  assign run_inc2 = (run_inc1 == {LW{1'b1}}) ? run_inc1 : run_inc1 + LW'(1);
  assign lit_done = ({1'b0, lidx_q} + 3'd1) >= jts_pkg::lit_len(lsel_q);

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_fire    = out_valid_o && !out_stall_i;
  assign in_stall_o  = !((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_fire));
  assign in_fire     = in_valid_i && !in_stall_o;

  assign token_kind_o   = buf_q[0].kind;
  assign token_start_o  = buf_q[0].start;
  assign token_length_o = buf_q[0].len;
  assign last_of_run_o  = buf_q[0].last;

  always_comb begin
    mode_d  = mode_q;
    lsel_d  = lsel_q;
    lidx_d  = lidx_q;
    start_d = start_q;
    err_d   = err_q;
    run_d   = run_q;
    pos_d   = pos_q + PW'(1);
    n_res   = 2'd0;
    do_idle = 1'b0;
    for (int i = 0; i < jts_pkg::MAX_RES; i++) begin
      res_d[i] = '0;
    end

    if (!err_q) begin
      case (mode_q)
        jts_pkg::MODE_LIT: begin
          run_d = run_inc1;
          if (b == jts_pkg::lit_char(lsel_q, lidx_q)) begin
            if (lit_done) begin
              res_d[n_res] = jts_pkg::mk_tok(jts_pkg::lit_kind(lsel_q), start_q, run_inc1);
              n_res        = n_res + 2'd1;
              mode_d       = jts_pkg::MODE_IDLE;
              lidx_d       = 2'd0;
            end else begin
              lidx_d = lidx_q + 2'd1;
            end
          end else begin
            res_d[n_res] = jts_pkg::mk_tok(jts_pkg::K_BADLIT, start_q, run_inc1);
            n_res        = n_res + 2'd1;
            err_d        = 1'b1;
            mode_d       = jts_pkg::MODE_IDLE;
          end
        end
        jts_pkg::MODE_STR: begin
          run_d = run_inc1;
          if (b == jts_pkg::CH_QUOTE) begin
            res_d[n_res] = jts_pkg::mk_tok(jts_pkg::K_STRING, start_q, run_inc1);
            n_res        = n_res + 2'd1;
            mode_d       = jts_pkg::MODE_IDLE;
          end
        end
        jts_pkg::MODE_INT: begin
          if (jts_pkg::is_digit(b)) begin
            run_d = run_inc1;
          end else if (b == jts_pkg::CH_DOT) begin
            mode_d = jts_pkg::MODE_DOT;
          end else begin
            res_d[n_res] = jts_pkg::mk_tok(jts_pkg::K_NUMBER, start_q, run_q);
            n_res        = n_res + 2'd1;
            mode_d       = jts_pkg::MODE_IDLE;
            do_idle      = 1'b1;
          end
        end
        jts_pkg::MODE_DOT: begin
          if (jts_pkg::is_digit(b)) begin
            run_d  = run_inc2;
            mode_d = jts_pkg::MODE_FRAC;
          end else begin
            // close the number before the dot, then flag the dot itself
            res_d[0] = jts_pkg::mk_tok(jts_pkg::K_NUMBER, start_q, run_q);
            res_d[1] = jts_pkg::mk_tok(jts_pkg::K_UNSUP, pos_q - PW'(1), LW'(1));
            n_res    = 2'd2;
            mode_d   = jts_pkg::MODE_IDLE;
            err_d    = 1'b1;
          end
        end
        jts_pkg::MODE_FRAC: begin
          if (jts_pkg::is_digit(b)) begin
            run_d = run_inc1;
          end else begin
            res_d[n_res] = jts_pkg::mk_tok(jts_pkg::K_NUMBER, start_q, run_q);
            n_res        = n_res + 2'd1;
            mode_d       = jts_pkg::MODE_IDLE;
            do_idle      = 1'b1;
          end
        end
        default: begin
          mode_d  = jts_pkg::MODE_IDLE;
          do_idle = 1'b1;
        end
      endcase
    end

    if (do_idle) begin
      case (b)
        jts_pkg::CH_LBRACE: begin
          res_d[n_res] = jts_pkg::mk_tok(jts_pkg::K_LBRACE, pos_q, LW'(1));
          n_res        = n_res + 2'd1;
        end
        jts_pkg::CH_RBRACE: begin
          res_d[n_res] = jts_pkg::mk_tok(jts_pkg::K_RBRACE, pos_q, LW'(1));
          n_res        = n_res + 2'd1;
        end
        jts_pkg::CH_LBRACK: begin
          res_d[n_res] = jts_pkg::mk_tok(jts_pkg::K_LBRACK, pos_q, LW'(1));
          n_res        = n_res + 2'd1;
        end
        jts_pkg::CH_RBRACK: begin
          res_d[n_res] = jts_pkg::mk_tok(jts_pkg::K_RBRACK, pos_q, LW'(1));
          n_res        = n_res + 2'd1;
        end
        jts_pkg::CH_COLON: begin
          res_d[n_res] = jts_pkg::mk_tok(jts_pkg::K_COLON, pos_q, LW'(1));
          n_res        = n_res + 2'd1;
        end
        jts_pkg::CH_COMMA: begin
          res_d[n_res] = jts_pkg::mk_tok(jts_pkg::K_COMMA, pos_q, LW'(1));
          n_res        = n_res + 2'd1;
        end
        jts_pkg::CH_T, jts_pkg::CH_F, jts_pkg::CH_N: begin
          lsel_d  = (b == jts_pkg::CH_T) ? jts_pkg::SEL_TRUE :
                    (b == jts_pkg::CH_F) ? jts_pkg::SEL_FALSE : jts_pkg::SEL_NULL;
          lidx_d  = 2'd0;
          mode_d  = jts_pkg::MODE_LIT;
          start_d = pos_q;
          run_d   = LW'(1);
        end
        jts_pkg::CH_QUOTE: begin
          mode_d  = jts_pkg::MODE_STR;
          start_d = pos_q;
          run_d   = LW'(1);
        end
        jts_pkg::CH_SPACE, jts_pkg::CH_TAB, jts_pkg::CH_LF, jts_pkg::CH_CR: begin
        end
        default: begin
          if (b == jts_pkg::CH_MINUS || jts_pkg::is_digit(b)) begin
            mode_d  = jts_pkg::MODE_INT;
            start_d = pos_q;
            run_d   = LW'(1);
          end else begin
            res_d[n_res] = jts_pkg::mk_tok(jts_pkg::K_UNSUP, pos_q, LW'(1));
            n_res        = n_res + 2'd1;
            err_d        = 1'b1;
          end
        end
      endcase
    end

    if (is_last_i) begin
      // close whatever is still open, then the end token
      if (!err_d) begin
        case (mode_d)
          jts_pkg::MODE_LIT: begin
            res_d[n_res] = jts_pkg::mk_tok(jts_pkg::K_BADLIT, start_d, run_d);
            n_res        = n_res + 2'd1;
          end
          jts_pkg::MODE_STR: begin
            res_d[n_res] = jts_pkg::mk_tok(jts_pkg::K_UNCLOSED, start_d, run_d);
            n_res        = n_res + 2'd1;
          end
          jts_pkg::MODE_INT, jts_pkg::MODE_FRAC: begin
            res_d[n_res] = jts_pkg::mk_tok(jts_pkg::K_NUMBER, start_d, run_d);
            n_res        = n_res + 2'd1;
          end
          jts_pkg::MODE_DOT: begin
            res_d[0] = jts_pkg::mk_tok(jts_pkg::K_NUMBER, start_d, run_d);
            res_d[1] = jts_pkg::mk_tok(jts_pkg::K_UNSUP, pos_q, LW'(1));
            n_res    = 2'd2;
          end
          default: begin
          end
        endcase
      end
      if (n_res != 2'd3) begin
        res_d[n_res] = jts_pkg::mk_tok(jts_pkg::K_END, pos_q + PW'(1), LW'(0));
        n_res        = n_res + 2'd1;
      end
      mode_d  = jts_pkg::MODE_IDLE;
      lsel_d  = 2'd0;
      lidx_d  = 2'd0;
      pos_d   = '0;
      start_d = '0;
      err_d   = 1'b0;
      run_d   = '0;
    end

    if (n_res != 2'd0) begin
      res_d[n_res - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= jts_pkg::MODE_IDLE;
      lsel_q  <= 2'd0;
      lidx_q  <= 2'd0;
      pos_q   <= '0;
      start_q <= '0;
      err_q   <= 1'b0;
      run_q   <= '0;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      lsel_q  <= lsel_d;
      lidx_q  <= lidx_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      err_q   <= err_d;
      run_q   <= run_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (in_fire) begin
      cnt_q <= n_res;
    end else if (out_fire) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // load a fresh group on accept, else advance the queue on each taken beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < jts_pkg::MAX_RES; i++) begin
        buf_q[i] <= res_d[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < jts_pkg::MAX_RES - 1; i++) begin
        buf_q[i] <= buf_q[i + 1];
      end
    end
  end

`ifndef SYNTH
  a_more_pending_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_run_o) |-> in_stall_o)
    else $error("input accepted while a token group is still draining");

  a_last_resets_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_last_i) |=> (pos_q == '0 && mode_q == jts_pkg::MODE_IDLE && !err_q))
    else $error("scanner state not cleared after last byte");

  a_last_ends_with_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_last_i) |=> (out_valid_o && buf_q[cnt_q - 2'd1].kind == jts_pkg::K_END))
    else $error("last byte did not produce a trailing end token");

  a_error_implies_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> (mode_q == jts_pkg::MODE_IDLE))
    else $error("error latched with a token still open");
`endif

endmodule

`default_nettype wire
